[design/tslr_pkg.sv]
// Shared types and constants for the linear resampler.
package tslr_pkg;
  localparam int TimeW = 34;
  localparam int ValW  = 32;
  localparam int StW   = 3;

  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_QUERY = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic [StW-1:0] ST_DONE   = 3'd0;
  localparam logic [StW-1:0] ST_EXACT  = 3'd1;
  localparam logic [StW-1:0] ST_LAST   = 3'd2;
  localparam logic [StW-1:0] ST_FIRST  = 3'd3;
  localparam logic [StW-1:0] ST_INTERP = 3'd4;
  localparam logic [StW-1:0] ST_EMPTY  = 3'd5;
  localparam logic [StW-1:0] ST_REJECT = 3'd6;

  // controller -> datapath
  typedef struct packed {
    logic capture;    // latch input transaction
    logic rd_last;    // read entry count-1
    logic rd_mid;     // read search midpoint
    logic rd_prev;    // read entry idx-1
    logic rd_idx;     // read entry idx
    logic srch_init;
    logic srch_step;
    logic load_exec;
    logic clear_exec;
    logic div_init;
    logic div_step;
    logic finish_q;   // form query result
    logic set_done;   // result for load/clear/unused op/empty query
  } tslr_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [1:0] op;
    logic       empty;
    logic       srch_done;
    logic       div_done;
    logic       need_div;
  } tslr_sts_t;
endpackage

[design/tslr_ctrl.sv]
// Controller sequencing load, query and clear transactions.
module tslr_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_fire,
  input  logic              out_free,
  input  tslr_pkg::tslr_sts_t sts,
  output tslr_pkg::tslr_cmd_t cmd,
  output logic              busy
);
  import tslr_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_DISP  = 9'b000000010,
    S_LRD   = 9'b000000100,
    S_LEX   = 9'b000001000,
    S_SRD   = 9'b000010000,
    S_SCMP  = 9'b000100000,
    S_NRD   = 9'b001000000,
    S_DIV   = 9'b010000000,
    S_OUT   = 9'b100000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    cmd = '0;
    state_next = state;
    unique case (state)
      S_IDLE: if (in_fire) begin
        cmd.capture = 1'b1;
        state_next = S_DISP;
      end
      S_DISP: begin
        if (sts.op == OP_LOAD) begin
          cmd.rd_last = 1'b1;
          state_next = S_LRD;
        end else if (sts.op == OP_QUERY && !sts.empty) begin
          cmd.srch_init = 1'b1;
          state_next = S_SRD;
        end else begin
          state_next = S_OUT;
        end
      end
      // keep the last entry on the read port until the load executes
      S_LRD: begin
        cmd.rd_last = 1'b1;
        state_next = S_LEX;
      end
      S_LEX: begin
        cmd.rd_last = 1'b1;
        if (out_free) begin
          cmd.load_exec = 1'b1;
          cmd.set_done = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_SRD: begin
        if (sts.srch_done) begin
          cmd.rd_prev = 1'b1;
          cmd.rd_idx = 1'b1;
          state_next = S_NRD;
        end else begin
          cmd.rd_mid = 1'b1;
          state_next = S_SCMP;
        end
      end
      S_SCMP: begin
        cmd.srch_step = 1'b1;
        state_next = S_SRD;
      end
      S_NRD: begin
        cmd.div_init = 1'b1;
        state_next = sts.need_div ? S_DIV : S_OUT;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) state_next = S_OUT;
      end
      S_OUT: if (out_free) begin
        if (sts.op == OP_QUERY && !sts.empty) cmd.finish_q = 1'b1;
        else begin
          cmd.set_done = 1'b1;
          cmd.clear_exec = (sts.op == OP_CLEAR);
        end
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule

[design/tslr_dp.sv]
// Datapath: sample memories, search registers, divider, result register.
module tslr_dp #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                       clk,
  input  logic                       rst,
  input  tslr_pkg::tslr_cmd_t        cmd,
  output tslr_pkg::tslr_sts_t        sts,
  input  logic [1:0]                 in_op,
  input  logic [tslr_pkg::TimeW-1:0] in_time,
  input  logic [tslr_pkg::ValW-1:0]  in_val,
  input  logic                       out_take,
  output logic                       out_valid,
  output logic [tslr_pkg::ValW-1:0]  out_val,
  output logic [tslr_pkg::StW-1:0]   out_st
);
  import tslr_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  // dividend m*a below 2^68, quotient below 2^33
  localparam int QW = 33;
  localparam int DW = 35;
  localparam int NW = 68;
  localparam int KW = $clog2(NW + 1);

  logic [TimeW-1:0] mem_t [TABLE_DEPTH];
  logic [ValW-1:0]  mem_v [TABLE_DEPTH];
  logic [TimeW-1:0] rd_t_a, rd_t_b;
  logic [ValW-1:0]  rd_v_a, rd_v_b;
  logic [AW-1:0]    addr_a, addr_b;
  logic             wr_t, wr_v;
  logic [AW-1:0]    wr_addr;

  logic [1:0]       op;
  logic [TimeW-1:0] tgt;
  logic [ValW-1:0]  val;
  logic [CW-1:0]    count;
  logic [CW-1:0]    lo, hi;
  logic [CW-1:0]    mid;

  logic [NW-1:0]    num;
  logic [DW-1:0]    den;
  logic [DW:0]      rem;
  logic [QW-1:0]    quo;
  logic [KW-1:0]    k;
  logic             neg;
  logic [StW-1:0]   qst;
  logic [ValW-1:0]  qval;

  assign mid = lo + ((hi - lo) >> 1);

  // read port A: last / mid / idx-1 ; port B: idx
  always_comb begin
    addr_a = mid[AW-1:0];
    if (cmd.rd_last) addr_a = AW'(count - 1'b1);
    else if (cmd.rd_prev) addr_a = (lo == '0) ? '0 : AW'(lo - 1'b1);
    addr_b = (lo >= count) ? AW'(count - 1'b1) : lo[AW-1:0];
  end

  always_ff @(posedge clk) begin
    rd_t_a <= mem_t[addr_a];
    rd_v_a <= mem_v[addr_a];
    rd_t_b <= mem_t[addr_b];
    rd_v_b <= mem_v[addr_b];
    if (wr_t) mem_t[wr_addr] <= tgt;
    if (wr_v) mem_v[wr_addr] <= val;
  end

  // load decision uses port A data (last entry)
  logic ld_eq, ld_app;
  assign ld_eq  = (count != '0) && (tgt == rd_t_a);
  assign ld_app = !((count != '0) && (tgt < rd_t_a)) && !ld_eq
                  && (count < CW'(TABLE_DEPTH));
  assign wr_addr = ld_eq ? AW'(count - 1'b1) : count[AW-1:0];
  assign wr_v = cmd.load_exec && (ld_eq || ld_app);
  assign wr_t = cmd.load_exec && ld_app;

  // neighbor arithmetic
  logic signed [ValW:0] dv;
  logic [ValW:0]        mag;
  assign dv  = $signed({rd_v_b[ValW-1], rd_v_b}) - $signed({rd_v_a[ValW-1], rd_v_a});
  assign mag = dv[ValW] ? (~dv + 1'b1) : dv;

  logic [DW:0] rem_sh, rem_sub;
  assign rem_sh  = {rem[DW-1:0], num[NW-1]};
  assign rem_sub = rem_sh - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load_exec && ld_app) count <= count + 1'b1;
      if (cmd.clear_exec) count <= '0;
      if (out_take) out_valid <= 1'b0;
      if (cmd.finish_q || cmd.set_done) out_valid <= 1'b1;
    end
    if (cmd.capture) begin
      op <= in_op; tgt <= in_time; val <= in_val;
    end
    if (cmd.srch_init) begin
      lo <= '0; hi <= count;
    end
    if (cmd.srch_step) begin
      if (rd_t_a < tgt) lo <= mid + 1'b1;
      else              hi <= mid;
    end
    if (cmd.div_init) begin
      neg <= dv[ValW];
      qval <= rd_v_a;
      if (lo < count && rd_t_b == tgt) begin
        qst <= ST_EXACT; qval <= rd_v_b;
      end else if (lo >= count) begin
        qst <= ST_LAST; qval <= rd_v_b;
      end else if (lo == '0) begin
        qst <= ST_FIRST; qval <= rd_v_b;
      end else begin
        qst <= ST_INTERP;
      end
      // m * a, m < 2^33, a < 2^34: one 33x34 product in this cycle
      num <= NW'(mag[QW-1:0]) * NW'(tgt - rd_t_a);
      den <= DW'(rd_t_b - rd_t_a);
      rem <= '0;
      quo <= '0;
      k <= '0;
    end
    if (cmd.div_step) begin
      num <= num << 1;
      k <= k + 1'b1;
      if (!rem_sub[DW]) begin
        rem <= rem_sub; quo <= {quo[QW-2:0], 1'b1};
      end else begin
        rem <= rem_sh;  quo <= {quo[QW-2:0], 1'b0};
      end
    end
    if (cmd.finish_q) begin
      out_st <= qst;
      if (qst == ST_INTERP)
        out_val <= neg ? qval - quo[ValW-1:0] : qval + quo[ValW-1:0];
      else
        out_val <= qval;
    end
    if (cmd.set_done) begin
      out_val <= '0;
      if (cmd.load_exec && !(ld_eq || ld_app)) out_st <= ST_REJECT;
      else if (op == OP_QUERY) out_st <= ST_EMPTY;
      else out_st <= ST_DONE;
    end
  end

  assign sts.op        = op;
  assign sts.empty     = (count == '0);
  assign sts.srch_done = (lo >= hi);
  assign sts.div_done  = (k == KW'(NW - 1));
  assign sts.need_div  = !(lo >= count) && !(rd_t_b == tgt) && (lo != '0);
endmodule

[design/time_series_linear_resampler_unit.sv]
// Top level of the one-series linear-interpolation resampler.
// Load, clear, unused-opcode and empty-query transactions skip the search; a query runs S search
// steps (at most 11 for 1024 entries), then the divider when interpolating (one quotient bit a
// cycle). One transaction in flight; the next can be accepted as soon as the result is registered;
// a stalled output holds back the next result.
// rst (synchronous, active high) empties the table; memory contents stay undefined.
module time_series_linear_resampler_unit #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,   // time_seconds[33:0], sample_value[65:34], zero pad
  input  logic [1:0]  s_tuser,   // operation
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // result_value[31:0]
  output logic [2:0]  m_tuser    // status
);
  import tslr_pkg::*;

  tslr_cmd_t cmd;
  tslr_sts_t sts;
  logic busy, in_fire, out_take;

  // Output register frees when taken; controller waits for it before finishing.
  assign s_tready = !busy;
  assign in_fire  = s_tvalid && s_tready;
  assign out_take = m_tvalid && m_tready;

  tslr_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_fire),
    .out_free(!m_tvalid || m_tready), .sts(sts), .cmd(cmd), .busy(busy)
  );

  tslr_dp #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts),
    .in_op(s_tuser), .in_time(s_tdata[33:0]), .in_val(s_tdata[65:34]),
    .out_take(out_take), .out_valid(m_tvalid),
    .out_val(m_tdata), .out_st(m_tuser)
  );

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !in_fire) else $error("accept while busy");
  a_fire_busy: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> busy) else $error("controller missed transaction");
  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.finish_q, cmd.set_done})) else $error("double result");
endmodule
